FILE: design/mkc_pkg.sv
// Shared types and constants for the keystream byte cipher.
package mkc_pkg;

    // Generator geometry and constants.
    localparam int unsigned STATE_WORDS_DEF = 624;
    localparam int unsigned MT_OFFSET       = 397;
    localparam logic [31:0] MT_MATRIX       = 32'h9908_B0DF;
    localparam logic [31:0] MT_MULT         = 32'h6C07_8965;
    localparam logic [31:0] MT_UPPER        = 32'h8000_0000;
    localparam logic [31:0] MT_LOWER        = 32'h7FFF_FFFF;
    localparam logic [31:0] TEMPER_B        = 32'h9D2C_5680;
    localparam logic [31:0] TEMPER_C        = 32'hEFC6_0000;
    localparam logic [31:0] SEED_BIAS       = 32'd6;

    // Additive key constants.
    localparam logic [7:0] KEY_INIT  = 8'hC5;
    localparam logic [7:0] STEP_INIT = 8'h83;
    localparam logic [7:0] STEP_INC  = 8'h53;

    // Queue depth between the front and back parts.
    localparam int unsigned QUEUE_DEPTH = 2;

    // One classified transaction waiting for the back part.
    typedef struct packed {
        logic [7:0] data;
        logic       reseed;
    } item_t;

    // Tempering of one generator word.
    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

FILE: design/mt19937_keystream_byte_cipher_unit.sv
// An ordinary byte is popped, two state words are read, and the twisted, tempered word
// sets the output byte; a reseeding byte first runs the serial seed multiply loop.
// A byte is popped only once the last result is registered; m_ready can hold this up.
// A two-entry queue lets input transactions be taken while the back part is busy.
// Synchronous active-low reset; the first byte after reset always reseeds the generator.
module mt19937_keystream_byte_cipher_unit #(
    parameter int unsigned STATE_WORDS = mkc_pkg::STATE_WORDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_start_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte
);

    logic [31:0]    header_length_reg;
    logic           q_valid, q_pop;
    mkc_pkg::item_t q_item;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_length_reg <= '0;
        end else if (cfg_wr_en) begin
            header_length_reg <= cfg_wr_data;
        end
    end

    mkc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_start_req (s_start_req),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    mkc_back #(
        .STATE_WORDS (STATE_WORDS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .header_length (header_length_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte)
    );

endmodule

FILE: design/mkc_front.sv
// Front part: accepts transactions, marks those that reseed, and queues them.
module mkc_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_data_byte,
    input  logic          s_start_req,
    output logic          q_valid,
    output mkc_pkg::item_t q_item,
    input  logic          q_pop
);

    localparam int unsigned PW = $clog2(mkc_pkg::QUEUE_DEPTH);

    mkc_pkg::item_t    mem_reg [mkc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]       count_reg;
    logic              init_pending_reg;
    logic              push;

    assign s_ready = (count_reg != PW'(0) + (PW+1)'(mkc_pkg::QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];

    // Queue storage; the first transaction after reset always reseeds.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg].data   <= s_data_byte;
            mem_reg[wr_ptr_reg].reseed <= s_start_req || init_pending_reg;
        end
    end

    // Queue pointers and the pending-seed flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
            init_pending_reg <= 1'b1;
        end else begin
            if (push) begin
                wr_ptr_reg       <= wr_ptr_reg + PW'(1);
                init_pending_reg <= 1'b0;
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_reg + (PW+1)'(push) - (PW+1)'(q_pop);
        end
    end

endmodule

FILE: design/mkc_back.sv
// Back part: generator seeding, on-the-fly twist, tempering and output register.
module mkc_back #(
    parameter int unsigned STATE_WORDS = mkc_pkg::STATE_WORDS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [31:0]    header_length,
    input  logic           q_valid,
    input  mkc_pkg::item_t q_item,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_byte
);

    localparam int unsigned KW   = $clog2(STATE_WORDS);
    localparam logic [KW-1:0] LAST = KW'(STATE_WORDS - 1);
    localparam logic [KW-1:0] WRAP = KW'(STATE_WORDS - mkc_pkg::MT_OFFSET);
    localparam logic [KW-1:0] OFFS = KW'(mkc_pkg::MT_OFFSET);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_SEED_MUL = 5'b00010,
        S_SEED_ADD = 5'b00100,
        S_READ     = 5'b01000,
        S_CALC     = 5'b10000
    } state_t;

    logic [31:0]   mt_mem [STATE_WORDS];
    state_t        state_reg;
    logic [KW-1:0] idx_reg;
    logic [KW-1:0] addr_a, addr_b;
    logic [31:0]   rd_a_reg, rd_b_reg;
    logic [31:0]   cur_reg, prev_reg, prod_reg;
    logic [7:0]    data_reg, key_reg, step_reg;
    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          mem_we;
    logic [KW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [31:0]   seed_val, y, v, t;
    logic          out_free;

    assign q_pop      = (state_reg == S_IDLE) && q_valid;
    assign m_valid    = out_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign out_free   = !out_valid_reg || m_ready;

    // Read addresses for the word after this one and the one at the offset.
    assign addr_a = (idx_reg == LAST) ? '0 : idx_reg + KW'(1);
    assign addr_b = (idx_reg >= WRAP) ? idx_reg - WRAP : idx_reg + OFFS;

    // Seeding and twist arithmetic.
    always_comb begin
        seed_val = prod_reg + 32'(idx_reg);
        y = (cur_reg & mkc_pkg::MT_UPPER) | (rd_a_reg & mkc_pkg::MT_LOWER);
        v = rd_b_reg ^ (y >> 1) ^ (y[0] ? mkc_pkg::MT_MATRIX : 32'd0);
        t = mkc_pkg::temper(v);
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = v;
        if (state_reg == S_IDLE) begin
            mem_we    = q_pop && q_item.reseed;
            mem_waddr = '0;
            mem_wdata = header_length + mkc_pkg::SEED_BIAS;
        end else if (state_reg == S_SEED_ADD) begin
            mem_we    = 1'b1;
            mem_wdata = seed_val;
        end else if (state_reg == S_CALC) begin
            mem_we = out_free;
        end
    end

    // State memory: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mt_mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == S_READ) begin
            rd_a_reg <= mt_mem[addr_a];
            rd_b_reg <= mt_mem[addr_b];
        end
    end

    // Sequencer and datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            key_reg       <= mkc_pkg::KEY_INIT;
            step_reg      <= mkc_pkg::STEP_INIT;
        end else begin
            // The output register empties on acceptance unless a new result replaces it.
            if (m_ready && (state_reg != S_CALC)) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_pop) begin
                        data_reg <= q_item.data;
                        if (q_item.reseed) begin
                            prev_reg  <= header_length + mkc_pkg::SEED_BIAS;
                            cur_reg   <= header_length + mkc_pkg::SEED_BIAS;
                            idx_reg   <= '0;
                            key_reg   <= mkc_pkg::KEY_INIT;
                            step_reg  <= mkc_pkg::STEP_INIT;
                            state_reg <= S_SEED_MUL;
                        end else begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_SEED_MUL: begin
                    prod_reg  <= (prev_reg ^ (prev_reg >> 30)) * mkc_pkg::MT_MULT;
                    idx_reg   <= idx_reg + KW'(1);
                    state_reg <= S_SEED_ADD;
                end
                S_SEED_ADD: begin
                    prev_reg <= seed_val;
                    if (idx_reg == LAST) begin
                        idx_reg   <= '0;
                        state_reg <= S_READ;
                    end else begin
                        state_reg <= S_SEED_MUL;
                    end
                end
                S_READ: begin
                    state_reg <= S_CALC;
                end
                S_CALC: begin
                    // Write back the twisted word and present the result.
                    if (out_free) begin
                        out_byte_reg  <= data_reg ^ t[7:0] ^ key_reg;
                        out_valid_reg <= 1'b1;
                        cur_reg       <= rd_a_reg;
                        idx_reg       <= addr_a;
                        key_reg       <= key_reg + step_reg;
                        step_reg      <= step_reg + mkc_pkg::STEP_INC;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
